/* rtl/ghpn_pkg.sv */
package ghpn_pkg;

	// Default sizing of the histogram.
	localparam int GHPN_BIN_COUNT   = 256;
	localparam int GHPN_COUNT_WIDTH = 24;

	// Fixed field widths.
	localparam int MODE_W     = 2;
	localparam int PIX_W      = 8;
	localparam int FH_W       = 10;
	localparam int BAR_W      = 10;
	localparam int RAW_W      = 24;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 40;

	// Reset value of the full-height register.
	localparam logic [FH_W-1:0] FH_RESET = 10'd400;

	// Command codes carried in tuser.
	localparam logic [MODE_W-1:0] MODE_COUNT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

	// Controller states.
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_COUNT,
		ST_MUL,
		ST_LOAD,
		ST_DIV,
		ST_OUT
	} ghpn_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic cnt_wr;
		logic clr_step;
		logic mul;
		logic div_load;
		logic div_step;
		logic out_load;
	} ghpn_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_last;
		logic div_last;
		logic out_free;
	} ghpn_stat_t;

endpackage

/* rtl/grey_histogram_peak_normalized.sv */
// Count (tuser 0): the bin is read, incremented and written back; the next item is taken after the write.
// Query (tuser 1): one multiply by the full height, then a restoring divider by the peak;
//   the result is loaded once the output register is free. The next item is taken once the result is loaded.
// Clear (tuser 2) and reset: a sweep zeroes one bin a cycle over all BIN_COUNT bins; no item
//   is taken meanwhile, configuration writes are. Reset sets full height to 400.
module grey_histogram_peak_normalized
	import ghpn_pkg::*;
#(
	parameter int BIN_COUNT   = GHPN_BIN_COUNT,
	parameter int COUNT_WIDTH = GHPN_COUNT_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// [7:0] pixel_value, [15:8] bin_index
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// [1:0] mode
	input  logic [MODE_W-1:0]     s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [9:0] bar_height, [33:10] raw_count, [39:34] zero
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [FH_W-1:0]       cfg_data
);

	ghpn_cmd_t  cmd;
	ghpn_stat_t stat;

	// The full-height register takes a write in any cycle.
	assign cfg_ready = 1'b1;

	ghpn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_mode  (s_axis_tuser),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ghpn_dp #(
		.BIN_COUNT   (BIN_COUNT),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_mode   (s_axis_tuser),
		.in_pixel  (s_axis_tdata[PIX_W-1:0]),
		.in_bin    (s_axis_tdata[2*PIX_W-1:PIX_W]),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata)
	);

endmodule

/* rtl/ghpn_ctrl.sv */
module ghpn_ctrl
	import ghpn_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [MODE_W-1:0] in_mode,
	output logic              in_ready,
	input  ghpn_stat_t        stat,
	output ghpn_cmd_t         cmd
);

	ghpn_state_t state_q;
	ghpn_state_t state_d;

	// State register; reset starts with a sweep that zeroes the bins.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					case (in_mode)
						MODE_COUNT: state_d = ST_COUNT;
						MODE_QUERY: state_d = ST_MUL;
						MODE_CLEAR: state_d = ST_CLEAR;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_COUNT: begin
				cmd.cnt_wr = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.div_load = 1'b1;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/ghpn_dp.sv */
module ghpn_dp
	import ghpn_pkg::*;
#(
	parameter int BIN_COUNT   = GHPN_BIN_COUNT,
	parameter int COUNT_WIDTH = GHPN_COUNT_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ghpn_cmd_t             cmd,
	output ghpn_stat_t            stat,
	input  logic [MODE_W-1:0]     in_mode,
	input  logic [PIX_W-1:0]      in_pixel,
	input  logic [PIX_W-1:0]      in_bin,
	input  logic                  cfg_valid,
	input  logic [FH_W-1:0]       cfg_data,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [OUT_DATA_W-1:0] out_data
);

	localparam int IDX_W  = $clog2(BIN_COUNT);
	localparam int PROD_W = COUNT_WIDTH + FH_W;
	localparam int DCNT_W = $clog2(FH_W);

	logic [COUNT_WIDTH-1:0] mem [BIN_COUNT];
	logic [IDX_W-1:0]       mod_tab [2**PIX_W];

	logic [IDX_W-1:0]       rd_idx;
	logic [IDX_W-1:0]       idx_q;
	logic [COUNT_WIDTH-1:0] rdata_q;
	logic [COUNT_WIDTH-1:0] inc;
	logic [COUNT_WIDTH-1:0] peak_q;
	logic [FH_W-1:0]        fh_q;
	logic [IDX_W-1:0]       clr_addr_q;
	logic [PROD_W-1:0]      prod_q;
	logic [COUNT_WIDTH-1:0] cnt_q;
	logic [COUNT_WIDTH-1:0] rem_q;
	logic [FH_W-1:0]        quo_q;
	logic [DCNT_W-1:0]      div_cnt_q;
	logic [COUNT_WIDTH:0]   trial;
	logic                   trial_ge;
	logic                   out_valid_q;
	logic [BAR_W-1:0]       bar_q;
	logic [RAW_W-1:0]       raw_q;

	// Grey level to bin number, folded modulo the bin count at elaboration.
	for (genvar g = 0; g < 2**PIX_W; g++) begin : g_mod
		localparam int M = g % BIN_COUNT;
		assign mod_tab[g] = IDX_W'(M);
	end

	// The read address comes straight from the input bus so that the bin
	// is ready the cycle after the transfer.
	assign rd_idx = (in_mode == MODE_QUERY) ? mod_tab[in_bin] : mod_tab[in_pixel];

	// Bin storage: one registered read port, one write port.
	always_ff @(posedge clk) begin
		rdata_q <= mem[rd_idx];
		if (cmd.clr_step) begin
			mem[clr_addr_q] <= '0;
		end else if (cmd.cnt_wr) begin
			mem[idx_q] <= inc;
		end
	end

	// Bin of the accepted item, for the write back.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			idx_q <= rd_idx;
		end
	end

	// Saturating increment.
	assign inc = (rdata_q == '1) ? rdata_q : rdata_q + COUNT_WIDTH'(1);

	// Peak tracking and clearing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= '0;
		end else if (cmd.clr_step) begin
			peak_q <= '0;
		end else if (cmd.cnt_wr && inc > peak_q) begin
			peak_q <= inc;
		end
	end

	// Clear sweep address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_step) begin
			if (stat.clr_last) begin
				clr_addr_q <= '0;
			end else begin
				clr_addr_q <= clr_addr_q + IDX_W'(1);
			end
		end
	end

	assign stat.clr_last = (clr_addr_q == IDX_W'(BIN_COUNT - 1));

	// Full-height register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fh_q <= FH_RESET;
		end else if (cfg_valid) begin
			fh_q <= cfg_data;
		end
	end

	// Product of the queried count and the full height.
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= PROD_W'(rdata_q) * PROD_W'(fh_q);
			cnt_q  <= rdata_q;
		end
	end

	// Restoring divider, one quotient bit a cycle. The count never exceeds
	// the peak, so the quotient fits the full-height width and the upper
	// product bits already form a partial remainder below the peak.
	assign trial    = {rem_q, quo_q[FH_W-1]};
	assign trial_ge = (trial >= {1'b0, peak_q});

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			rem_q     <= prod_q[PROD_W-1:FH_W];
			quo_q     <= prod_q[FH_W-1:0];
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			if (trial_ge) begin
				rem_q <= COUNT_WIDTH'(trial - {1'b0, peak_q});
			end else begin
				rem_q <= trial[COUNT_WIDTH-1:0];
			end
			quo_q     <= {quo_q[FH_W-2:0], trial_ge};
			div_cnt_q <= div_cnt_q + DCNT_W'(1);
		end
	end

	assign stat.div_last = (div_cnt_q == DCNT_W'(FH_W - 1));

	// Output register; an empty histogram gives height zero.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			bar_q <= (peak_q == '0) ? '0 : BAR_W'(quo_q);
			raw_q <= RAW_W'(cnt_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.out_free = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign out_data      = {(OUT_DATA_W - BAR_W - RAW_W)'(0), raw_q, bar_q};

`ifndef NO_ASSERTIONS
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.cnt_wr, cmd.clr_step, cmd.mul, cmd.div_load, cmd.div_step,
			cmd.out_load}))
		else $error("datapath commands overlap");

	a_peak_covers: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_wr |=> peak_q >= $past(inc))
		else $error("peak below a freshly written count");

	a_out_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result overwrites an unsent result");

	a_quo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && peak_q != '0) |-> (quo_q <= fh_q))
		else $error("bar height above full height");
`endif

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps

module tb;
	import ghpn_pkg::*;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	// Longest quiet stretch: a clearing sweep, a query and a full hold-off, several times over.
	localparam int QUIET_LIMIT = 5000;
	// Cycles to let pass before a register write, covering a clearing sweep.
	localparam int SETTLE_CYCLES = 300;

	typedef struct {
		logic [MODE_W-1:0] op;
		logic [PIX_W-1:0]  pixel;
		logic [PIX_W-1:0]  bin;
	} hist_cmd_t;

	typedef struct {
		logic [BAR_W-1:0] bar;
		logic [RAW_W-1:0] raw;
	} bar_reading_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [MODE_W-1:0]     s_axis_tuser = MODE_COUNT;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [FH_W-1:0]       cfg_data = '0;

	// Local copy of the histogram state and the height register.
	logic [GHPN_COUNT_WIDTH-1:0] bin_tally [GHPN_BIN_COUNT] = '{default: '0};
	logic [GHPN_COUNT_WIDTH-1:0] peak_tally = '0;
	logic [FH_W-1:0]             full_height_model = FH_RESET;

	hist_cmd_t    pending_cmds[$];
	bar_reading_t expected_bars[$];
	hist_cmd_t    next_cmd;
	bar_reading_t want_bar;
	logic [PIX_W-1:0] hot_pixels [4];

	int send_idle_pct = 31;
	int recv_idle_pct = 64;
	int mismatch_count = 0;
	int quiet_cycles = 0;

	grey_histogram_peak_normalized dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Update the histogram copy for one accepted command; a query yields one expected reading.
	function automatic void apply_hist_cmd(input logic [MODE_W-1:0] op,
			input logic [PIX_W-1:0] pixel, input logic [PIX_W-1:0] bin);
		logic [GHPN_COUNT_WIDTH-1:0] tally;
		longint unsigned scaled;
		bar_reading_t reading;
		case (op)
			MODE_COUNT: begin
				tally = bin_tally[pixel];
				if (tally != '1)
					tally = tally + GHPN_COUNT_WIDTH'(1);
				bin_tally[pixel] = tally;
				if (tally > peak_tally)
					peak_tally = tally;
			end
			MODE_QUERY: begin
				tally = bin_tally[bin];
				scaled = 0;
				if (peak_tally != '0) begin
					scaled = 64'(tally);
					scaled = (scaled * full_height_model) / peak_tally;
				end
				reading.bar = scaled[BAR_W-1:0];
				reading.raw = tally[RAW_W-1:0];
				expected_bars.push_back(reading);
			end
			MODE_CLEAR: begin
				foreach (bin_tally[i])
					bin_tally[i] = '0;
				peak_tally = '0;
			end
			default: begin
			end
		endcase
	endfunction

	// Mostly counts and queries around a few busy grey levels, so the peak moves and
	// heights take many values; clears and the unused mode are rare.
	function automatic hist_cmd_t random_cmd();
		hist_cmd_t cmd;
		int roll;
		roll = $urandom_range(99);
		cmd.pixel = PIX_W'($urandom_range(255));
		cmd.bin = PIX_W'($urandom_range(255));
		if (roll < 60) begin
			cmd.op = MODE_COUNT;
			if ($urandom_range(1))
				cmd.pixel = hot_pixels[$urandom_range(3)];
		end else if (roll < 95) begin
			cmd.op = MODE_QUERY;
			if ($urandom_range(1))
				cmd.bin = hot_pixels[$urandom_range(3)];
		end else if (roll < 98) begin
			cmd.op = MODE_CLEAR;
		end else begin
			cmd.op = MODE_UNUSED;
		end
		return cmd;
	endfunction

	task automatic queue_cmd(input logic [MODE_W-1:0] op, input logic [PIX_W-1:0] pixel,
			input logic [PIX_W-1:0] bin);
		hist_cmd_t cmd;
		cmd.op = op;
		cmd.pixel = pixel;
		cmd.bin = bin;
		pending_cmds.push_back(cmd);
	endtask

	// Wait until every queued command has been sent and every reading has come back.
	task automatic wait_drained();
		while (pending_cmds.size() != 0 || s_axis_tvalid || expected_bars.size() != 0)
			@(posedge clk);
	endtask

	// Let the block go idle, then transfer a new full height.
	task automatic set_full_height(input logic [FH_W-1:0] height);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= height;
		do
			@(posedge clk);
		while (!cfg_ready);
		full_height_model = height;
		cfg_valid <= 1'b0;
	endtask

	// Command driver: when the slot is free, offers the next queued command or, at random, idles.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				apply_hist_cmd(s_axis_tuser, s_axis_tdata[PIX_W-1:0],
					s_axis_tdata[IN_DATA_W-1:PIX_W]);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_cmd = pending_cmds.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tuser <= next_cmd.op;
					s_axis_tdata <= {next_cmd.bin, next_cmd.pixel};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Reading monitor: random back-pressure and a field-by-field compare of each transfer.
	always @(posedge clk) begin
		if (arst_n) begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_bars.size() == 0) begin
					$display("%0t: unexpected reading %h", $time, m_axis_tdata);
					mismatch_count++;
				end else begin
					want_bar = expected_bars.pop_front();
					if (m_axis_tdata[BAR_W-1:0] !== want_bar.bar) begin
						$display("%0t: bar_height expected %0d actual %0d", $time,
							want_bar.bar, m_axis_tdata[BAR_W-1:0]);
						mismatch_count++;
					end
					if (m_axis_tdata[BAR_W +: RAW_W] !== want_bar.raw) begin
						$display("%0t: raw_count expected %0d actual %0d", $time,
							want_bar.raw, m_axis_tdata[BAR_W +: RAW_W]);
						mismatch_count++;
					end
				end
			end
		end
	end

	// Watchdog: too long without any transfer means the block has hung.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		logic [FH_W-1:0] phase_heights [6];
		phase_heights[0] = 10'd1023;
		phase_heights[1] = 10'd1;
		phase_heights[2] = FH_W'($urandom_range(2, 1022));
		phase_heights[3] = FH_RESET;
		phase_heights[4] = 10'd1023;
		phase_heights[5] = FH_W'($urandom_range(1, 1023));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset height: empty histogram, extremes, unused mode, clear.
		queue_cmd(MODE_QUERY, 8'h00, 8'h00);
		queue_cmd(MODE_QUERY, 8'h00, 8'hFF);
		queue_cmd(MODE_COUNT, 8'h00, 8'hFF);
		queue_cmd(MODE_COUNT, 8'hFF, 8'h00);
		queue_cmd(MODE_COUNT, 8'h00, 8'h55);
		queue_cmd(MODE_COUNT, 8'hAA, 8'hAA);
		queue_cmd(MODE_COUNT, 8'h55, 8'h00);
		queue_cmd(MODE_COUNT, 8'h00, 8'h00);
		queue_cmd(MODE_QUERY, 8'hFF, 8'h00);
		queue_cmd(MODE_QUERY, 8'h00, 8'hFF);
		queue_cmd(MODE_QUERY, 8'hAA, 8'h55);
		queue_cmd(MODE_QUERY, 8'h00, 8'h12);
		queue_cmd(MODE_UNUSED, 8'hFF, 8'hFF);
		queue_cmd(MODE_QUERY, 8'h00, 8'h00);
		queue_cmd(MODE_CLEAR, 8'h00, 8'h00);
		queue_cmd(MODE_QUERY, 8'h00, 8'h00);
		queue_cmd(MODE_COUNT, 8'h80, 8'hFF);
		queue_cmd(MODE_QUERY, 8'hFF, 8'h80);

		// A zero full height flattens every bar.
		set_full_height('0);
		queue_cmd(MODE_COUNT, 8'h33, 8'h00);
		queue_cmd(MODE_COUNT, 8'h33, 8'h00);
		queue_cmd(MODE_COUNT, 8'h01, 8'h00);
		queue_cmd(MODE_QUERY, 8'h00, 8'h33);
		queue_cmd(MODE_QUERY, 8'h00, 8'h01);

		// Random phases under changing heights and idling patterns.
		for (int phase = 0; phase < 6; phase++) begin
			set_full_height(phase_heights[phase]);
			send_idle_pct = (phase < 2) ? 31 : ((phase < 4) ? 64 : 0);
			recv_idle_pct = (phase < 2) ? 64 : ((phase < 4) ? 31 : 0);
			foreach (hot_pixels[i])
				hot_pixels[i] = PIX_W'($urandom_range(255));
			for (int n = 0; n < 80; n++) begin
				// Once, hold the stream back until every reading is in.
				if (phase == 1 && n == 40)
					wait_drained();
				pending_cmds.push_back(random_cmd());
			end
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
